// ----- design/qrs_pkg.sv -----
package qrs_pkg;

   // widest coefficient the ports carry; bits above COEF_WIDTH are ignored
   localparam int CoefMax = 32;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_INVALID  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [CoefMax-1:0] coef_a;
      logic [CoefMax-1:0] coef_b;
      logic [CoefMax-1:0] coef_c;
   } req_type;

   typedef struct packed {
      kind_type           root_kind;
      logic signed [31:0] root_first;
      logic signed [31:0] root_second;
      logic               saturated;
   } rsp_type;

endpackage

// ----- design/qrs_sqrt_cell.sv -----
module qrs_sqrt_cell #(
   parameter int SW = 33,
   parameter int TW = 34
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*SW-1:0] in_rad,
   input  logic [SW+2:0]   in_rem,
   input  logic [SW-1:0]   in_root,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [2*SW-1:0] out_rad,
   output logic [SW+2:0]   out_rem,
   output logic [SW-1:0]   out_root,
   output logic [TW-1:0]   out_tag
);
   localparam int RMW = SW + 3;

   logic [RMW-1:0] rem_sh;
   logic [RMW-1:0] trial;
   logic [RMW:0]   diff;
   logic           ge;
   logic           valid_ff;
   logic [2*SW-1:0] rad_ff, rad_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [SW-1:0]  root_ff, root_in;
   logic [TW-1:0]  tag_ff;

   // one root bit per cell: bring down two radicand bits, try 4r+1
   assign rem_sh  = {in_rem[RMW-3:0], in_rad[2*SW-1 -: 2]};
   assign trial   = {1'b0, in_root, 2'b01};
   assign diff    = {1'b0, rem_sh} - {1'b0, trial};
   assign ge      = ~diff[RMW];
   assign rem_in  = ge ? diff[RMW-1:0] : rem_sh;
   assign root_in = {in_root[SW-2:0], ge};
   assign rad_in  = {in_rad[2*SW-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- design/qrs_div_cell.sv -----
module qrs_div_cell #(
   parameter int NW  = 36,
   parameter int DVW = 18,
   parameter int TW  = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [NW-1:0]  in_num,
   input  logic [DVW-1:0] in_rem,
   input  logic [DVW-1:0] in_dv,
   input  logic [TW-1:0]  in_tag,
   output logic           out_valid,
   output logic [NW-1:0]  out_num,
   output logic [DVW-1:0] out_rem,
   output logic [DVW-1:0] out_dv,
   output logic [TW-1:0]  out_tag
);
   logic [DVW:0]   rem_sh;
   logic [DVW+1:0] diff;
   logic           ge;
   logic           valid_ff;
   logic [NW-1:0]  num_ff, num_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dv_ff;
   logic [TW-1:0]  tag_ff;

   // restoring step: numerator shifts out on top, quotient bit enters below
   assign rem_sh = {in_rem, in_num[NW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, in_dv};
   assign ge     = ~diff[DVW+1];
   assign rem_in = ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
   assign num_in = {in_num[NW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         dv_ff  <= in_dv;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_dv    = dv_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- design/quadratic_root_solver.sv -----
// quadratic root solver: takes signed Q8.8 coefficients a, b, c (low COEF_WIDTH bits of
// each field) and returns the roots of a*x^2+b*x+c=0 in signed Q16.16 with a kind code:
// two real, double (second root 0), complex pair (real part, imaginary part carrying the
// sign of a) or invalid when a is zero (both roots 0). quotients round to nearest with
// ties away from zero and clip to 32 bits, raising saturated. one coefficient set is
// taken per clock; a set passes through the capture, product and discriminant stages,
// the row of square-root cells (one root bit each), stage 3 and the divider cells
// (one quotient bit each) into a two-entry output buffer, which lets new sets enter
// while a result waits; the pipeline only holds when that buffer is full.
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int W   = COEF_WIDTH;
   localparam int SW  = W + 17;       // root bits
   localparam int RW  = 2 * SW;       // radicand bits
   localparam int NW  = W + 20;       // numerator and quotient bits
   localparam int DVW = W + 2;        // divisor bits (4*|a|)
   localparam int STW = 2 + 2 * W;    // side data through the root row

   function automatic logic [32:0] clip(input logic [63:0] q, input logic neg);
      logic [32:0] r;
      if (neg) begin
         if (q > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else                   r = {1'b0, 32'(64'd0 - q)};
      end else begin
         if (q > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else                   r = {1'b0, q[31:0]};
      end
      return r;
   endfunction

   logic en;
   logic fifo_full;

   // stage 0: capture coefficients
   logic                v0_ff;
   logic signed [W-1:0] a0_ff, b0_ff, c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= req_data.coef_a[W-1:0];
         b0_ff <= req_data.coef_b[W-1:0];
         c0_ff <= req_data.coef_c[W-1:0];
      end
   end

   // stage 1: products b*b and a*c
   logic                  v1_ff;
   logic signed [W-1:0]   a1_ff, b1_ff;
   logic signed [2*W-1:0] bb1_ff, bb1_in, ac1_ff, ac1_in;

   assign bb1_in = b0_ff * b0_ff;
   assign ac1_in = a0_ff * c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
         bb1_ff <= bb1_in;
         ac1_ff <= ac1_in;
      end
   end

   // stage 2: discriminant, its magnitude and the kind of roots
   logic signed [2*W+1:0] disc;
   logic [2*W+1:0]        disc_abs;
   logic                  v2_ff;
   logic signed [W-1:0]   a2_ff, b2_ff;
   logic [2*W:0]          dmag2_ff;
   kind_type              kind2_ff, kind2_in;

   assign disc     = (2*W+2)'(bb1_ff) - ((2*W+2)'(ac1_ff) <<< 2);
   assign disc_abs = disc[2*W+1] ? -disc : disc;

   always_comb begin
      priority if (a1_ff == '0) kind2_in = KIND_INVALID;
      else if (disc[2*W+1])     kind2_in = KIND_COMPLEX;
      else if (disc == '0)      kind2_in = KIND_DOUBLE;
      else                      kind2_in = KIND_TWO_REAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         dmag2_ff <= disc_abs[2*W:0];
         kind2_ff <= kind2_in;
      end
   end

   // square-root row: floor(sqrt(|d| * 2^32)), one bit per cell
   logic            sq_v    [SW+1];
   logic [RW-1:0]   sq_rad  [SW+1];
   logic [SW+2:0]   sq_rem  [SW+1];
   logic [SW-1:0]   sq_root [SW+1];
   logic [STW-1:0]  sq_tag  [SW+1];

   assign sq_v[0]    = v2_ff;
   assign sq_rad[0]  = {1'b0, dmag2_ff, 32'h0};
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_tag[0]  = {kind2_ff, a2_ff, b2_ff};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SW(SW), .TW(STW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_tag    (sq_tag[i]),
         .out_valid (sq_v[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_tag   (sq_tag[i+1])
      );
   end

   // stage 3: signed numerators, magnitudes and rounding offset for both divides
   logic [1:0]           t_kind;
   logic signed [W-1:0]  t_a, t_b;
   logic [W-1:0]         abs_a;
   logic signed [W+18:0] nb, sv, n1, n2;
   logic [W+18:0]        u1, u2;
   logic                 v3_ff;
   logic [NW-1:0]        num1_ff, num1_in, num2_ff, num2_in;
   logic [DVW-1:0]       dv3_ff;
   logic [1:0]           kind3_ff;
   logic                 neg1_ff, neg2_ff;

   assign t_kind = sq_tag[SW][STW-1 -: 2];
   assign t_a    = sq_tag[SW][2*W-1 -: W];
   assign t_b    = sq_tag[SW][W-1:0];
   assign abs_a  = t_a[W-1] ? W'(-t_a) : t_a;
   assign nb     = -($signed({{3{t_b[W-1]}}, t_b, 16'h0}));
   assign sv     = $signed({2'b00, sq_root[SW]});

   always_comb begin
      unique case (t_kind)
         KIND_TWO_REAL: begin
            n1 = nb + sv;
            n2 = nb - sv;
         end
         KIND_DOUBLE: begin
            n1 = nb;
            n2 = '0;
         end
         KIND_COMPLEX: begin
            n1 = nb;
            n2 = sv;
         end
         default: begin
            n1 = '0;
            n2 = '0;
         end
      endcase
   end

   assign u1 = n1[W+18] ? -n1 : n1;
   assign u2 = n2[W+18] ? -n2 : n2;
   // (2|n| + 2|a|) / (4|a|) rounds half away from zero
   assign num1_in = NW'({u1[W+17:0], 1'b0}) + NW'({abs_a, 1'b0});
   assign num2_in = NW'({u2[W+17:0], 1'b0}) + NW'({abs_a, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_v[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff  <= num1_in;
         num2_ff  <= num2_in;
         dv3_ff   <= {abs_a, 2'b00};
         kind3_ff <= t_kind;
         neg1_ff  <= n1[W+18] ^ t_a[W-1];
         neg2_ff  <= n2[W+18] ^ t_a[W-1];
      end
   end

   // two divider rows side by side, one quotient bit per cell
   logic            d1_v   [NW+1];
   logic [NW-1:0]   d1_num [NW+1];
   logic [DVW-1:0]  d1_rem [NW+1];
   logic [DVW-1:0]  d1_dv  [NW+1];
   logic [2:0]      d1_tag [NW+1];
   logic            d2_v   [NW+1];
   logic [NW-1:0]   d2_num [NW+1];
   logic [DVW-1:0]  d2_rem [NW+1];
   logic [DVW-1:0]  d2_dv  [NW+1];
   logic [0:0]      d2_tag [NW+1];

   assign d1_v[0]   = v3_ff;
   assign d1_num[0] = num1_ff;
   assign d1_rem[0] = '0;
   assign d1_dv[0]  = dv3_ff;
   assign d1_tag[0] = {kind3_ff, neg1_ff};
   assign d2_v[0]   = v3_ff;
   assign d2_num[0] = num2_ff;
   assign d2_rem[0] = '0;
   assign d2_dv[0]  = dv3_ff;
   assign d2_tag[0] = neg2_ff;

   for (genvar j = 0; j < NW; j++) begin : g_div
      qrs_div_cell #(.NW(NW), .DVW(DVW), .TW(3)) u_first (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (d1_v[j]),
         .in_num    (d1_num[j]),
         .in_rem    (d1_rem[j]),
         .in_dv     (d1_dv[j]),
         .in_tag    (d1_tag[j]),
         .out_valid (d1_v[j+1]),
         .out_num   (d1_num[j+1]),
         .out_rem   (d1_rem[j+1]),
         .out_dv    (d1_dv[j+1]),
         .out_tag   (d1_tag[j+1])
      );
      qrs_div_cell #(.NW(NW), .DVW(DVW), .TW(1)) u_second (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (d2_v[j]),
         .in_num    (d2_num[j]),
         .in_rem    (d2_rem[j]),
         .in_dv     (d2_dv[j]),
         .in_tag    (d2_tag[j]),
         .out_valid (d2_v[j+1]),
         .out_num   (d2_num[j+1]),
         .out_rem   (d2_rem[j+1]),
         .out_dv    (d2_dv[j+1]),
         .out_tag   (d2_tag[j+1])
      );
   end

   // clip quotients, apply sign and kind overrides
   logic        last_v;
   kind_type    f_kind;
   logic [32:0] c1, c2;
   rsp_type     result;

   assign last_v = d1_v[NW];
   assign f_kind = kind_type'(d1_tag[NW][2:1]);
   assign c1 = clip(64'(d1_num[NW]), d1_tag[NW][0]);
   assign c2 = clip(64'(d2_num[NW]), d2_tag[NW][0]);

   always_comb begin
      result.root_kind = f_kind;
      unique case (f_kind)
         KIND_INVALID: begin
            result.root_first  = '0;
            result.root_second = '0;
            result.saturated   = 1'b0;
         end
         KIND_DOUBLE: begin
            result.root_first  = c1[31:0];
            result.root_second = '0;
            result.saturated   = c1[32];
         end
         default: begin
            result.root_first  = c1[31:0];
            result.root_second = c2[31:0];
            result.saturated   = c1[32] | c2[32];
         end
      endcase
   end

   // two-entry output buffer; the whole pipeline holds only when it is full
   rsp_type    buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign fifo_full = (cnt_ff == 2'd2);
   assign en        = !(fifo_full && last_v);
   assign push      = en && last_v;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = en;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= result;
      end
   end

   // buffer never overfills and never takes a transfer while full
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("push into full output buffer");

   // a held pipeline keeps its last result in place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(d1_num[NW]) && $stable(d2_num[NW]))
      else $error("pipeline moved while held");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_INVALID |->
         rsp_data.root_first == '0 && rsp_data.root_second == '0 && !rsp_data.saturated)
      else $error("invalid kind with nonzero roots");

   a_double_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_DOUBLE |-> rsp_data.root_second == '0)
      else $error("double root with nonzero second root");

endmodule
